[src/zffa_pkg.sv]
// package for the zoned first-fit extent allocator
// extent entry type, table geometry and status codes; no dependencies
package zffa_pkg;

  localparam int MAX_ZONES   = 16;
  localparam int MAX_EXTENTS = 16;
  localparam int ZONE_W      = 4;
  localparam int SLOT_W      = 4;
  localparam int CNT_W       = 5;
  localparam int START_W     = 21;
  localparam int SIZE_W      = 22;
  localparam int ADDR_W      = ZONE_W + SLOT_W;
  localparam int ENTRY_W     = START_W + SIZE_W;
  localparam int DEPTH       = MAX_ZONES * MAX_EXTENTS;

  localparam logic [SIZE_W-1:0] ZONE_BYTES    = SIZE_W'(1) << START_W;
  localparam logic [CNT_W-1:0]  ZONES_RESET   = CNT_W'(16);
  localparam logic [CNT_W-1:0]  EXTENTS_LIMIT = CNT_W'(MAX_EXTENTS);

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FIT  = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [SIZE_W-1:0]  size;
  } ext_t;

endpackage

[src/zoned_first_fit_extent_allocator_unit.sv]
// top level of the zoned first-fit extent allocator
// uses zffa_pkg and one zffa_ram holding the extent tables of all zones
//
// usage: a request is taken when start is high and busy is low. func 0
// allocates length bytes; func 1 frees length bytes at offset in zone.
// one result per request appears for a single cycle with done high:
// status, out_zone, out_offset. the receiver cannot stall the result.
// zones_in_use is written on the cfg channel (cfg_valid/cfg_ready), taken
// only while idle; a pending write holds busy high so no request slips by.
// a write reinitialises every zone to one free extent.
// an allocate examines table slots in turn, each with a ram read then a
// compare, and passes on to the next zone when a zone runs out; an exact
// fit then moves each later slot down, a read then a write per slot. a
// free scans up to the insert point the same way, then merges (moving
// later slots down when it joins both neighbours) or moves later slots up
// and inserts. the single ram read port reads one slot at a time.
// throughput: one request at a time; busy drops the cycle after done unless cfg_valid is high.
// reset: zones_in_use is 16 and every zone holds one extent covering the
// whole zone; per-zone fresh bits stand in for slot 0, so no clearing pass.
module zoned_first_fit_extent_allocator_unit
  import zffa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               func,
  input  logic [SIZE_W-1:0]  length,
  input  logic [START_W-1:0] offset,
  input  logic [ZONE_W-1:0]  zone,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CNT_W-1:0]   cfg_data,
  output logic               done,
  output logic [1:0]         status,
  output logic [ZONE_W-1:0]  out_zone,
  output logic [START_W-1:0] out_offset
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_A_CHK = 4'd1;
  localparam logic [3:0] S_A_CMP = 4'd2;
  localparam logic [3:0] S_F_CHK = 4'd3;
  localparam logic [3:0] S_F_CMP = 4'd4;
  localparam logic [3:0] S_F_DEC = 4'd5;
  localparam logic [3:0] S_SD_RD = 4'd6;
  localparam logic [3:0] S_SD_WR = 4'd7;
  localparam logic [3:0] S_SU_RD = 4'd8;
  localparam logic [3:0] S_SU_WR = 4'd9;
  localparam logic [3:0] S_F_INS = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0]           state;
  logic [CNT_W-1:0]     zones;
  logic [CNT_W-1:0]     cnt [MAX_ZONES];
  logic [MAX_ZONES-1:0] fresh;
  logic [ZONE_W-1:0]    zn;
  logic [CNT_W-1:0]     si;
  logic [CNT_W-1:0]     sj;
  logic [SIZE_W-1:0]    len_r;
  logic [START_W-1:0]   off_r;
  ext_t                 prev;
  ext_t                 cur;
  logic                 has_cur;
  logic                 rfix;

  logic                 we;
  logic [ADDR_W-1:0]    waddr;
  ext_t                 wdata;
  logic [ADDR_W-1:0]    raddr;
  logic [ENTRY_W-1:0]   rdata;
  logic [SLOT_W-1:0]    rslot;
  logic [SLOT_W-1:0]    wslot;
  ext_t                 ent;

  logic [CNT_W-1:0]     cnt_z;
  logic [CNT_W-1:0]     si_m1;
  logic [CNT_W-1:0]     sj_m1;
  logic [CNT_W-1:0]     zn_p1;
  logic [SIZE_W:0]      fend_in;
  logic [SIZE_W:0]      fend;
  logic [SIZE_W:0]      prev_end;
  logic                 mp;
  logic                 ms;
  logic [CNT_W-1:0]     cfg_clamped;
  ext_t                 init_ext;

  assign busy      = (state != S_IDLE) || cfg_valid;
  assign cfg_ready = (state == S_IDLE);
  assign done      = (state == S_DONE);

  assign cnt_z    = cnt[zn];
  assign si_m1    = si - CNT_W'(1);
  assign sj_m1    = sj - CNT_W'(1);
  assign zn_p1    = {1'b0, zn} + CNT_W'(1);
  assign fend_in  = {2'b0, offset} + {1'b0, length};
  assign fend     = {2'b0, off_r} + {1'b0, len_r};
  assign prev_end = {2'b0, prev.start} + {1'b0, prev.size};
  assign mp       = (si != '0) && (prev_end == {2'b0, off_r});
  assign ms       = has_cur && (fend == {2'b0, cur.start});

  assign init_ext.start = '0;
  assign init_ext.size  = ZONE_BYTES;

  always_comb begin
    if (cfg_data == '0) begin
      cfg_clamped = CNT_W'(1);
    end else if (cfg_data > CNT_W'(MAX_ZONES)) begin
      cfg_clamped = CNT_W'(MAX_ZONES);
    end else begin
      cfg_clamped = cfg_data;
    end
  end

  // read address: shift-up reads the slot below the move target
  assign rslot = (state == S_SU_RD) ? sj_m1[SLOT_W-1:0] : si[SLOT_W-1:0];
  assign raddr = {zn, rslot};
  assign ent   = rfix ? init_ext : ext_t'(rdata);

  always_comb begin
    we    = 1'b0;
    wslot = si[SLOT_W-1:0];
    wdata = ent;
    case (state)
      S_A_CMP: begin
        if (ent.size > len_r) begin
          we          = 1'b1;
          wdata.start = ent.start + len_r[START_W-1:0];
          wdata.size  = ent.size - len_r;
        end
      end
      S_SD_WR: begin
        we    = 1'b1;
        wslot = si_m1[SLOT_W-1:0];
      end
      S_SU_WR: begin
        we    = 1'b1;
        wslot = sj[SLOT_W-1:0];
      end
      S_F_DEC: begin
        wslot = si_m1[SLOT_W-1:0];
        wdata = prev;
        if (mp && ms) begin
          we         = 1'b1;
          wdata.size = prev.size + len_r + cur.size;
        end else if (mp) begin
          we         = 1'b1;
          wdata.size = prev.size + len_r;
        end else if (ms) begin
          we          = 1'b1;
          wslot       = si[SLOT_W-1:0];
          wdata.start = off_r;
          wdata.size  = cur.size + len_r;
        end
      end
      S_F_INS: begin
        we          = 1'b1;
        wdata.start = off_r;
        wdata.size  = len_r;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign waddr = {zn, wslot};

  zffa_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    rfix <= fresh[zn] && (rslot == '0);
    if (rst) begin
      state <= S_IDLE;
      zones <= ZONES_RESET;
      zn    <= '0;
      fresh <= '1;
      for (int z = 0; z < MAX_ZONES; z++) begin
        cnt[z] <= CNT_W'(1);
      end
    end else begin
      if (we && wslot == '0) begin
        fresh[zn] <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            zones <= cfg_clamped;
            fresh <= '1;
            for (int z = 0; z < MAX_ZONES; z++) begin
              cnt[z] <= CNT_W'(1);
            end
          end else if (start) begin
            len_r      <= length;
            off_r      <= offset;
            si         <= '0;
            has_cur    <= 1'b0;
            out_zone   <= '0;
            out_offset <= '0;
            if (length == '0) begin
              status <= ST_INVALID;
              state  <= S_DONE;
            end else if (!func) begin
              status <= ST_OK;
              zn     <= '0;
              state  <= S_A_CHK;
            end else if ({1'b0, zone} >= zones || fend_in > {1'b0, ZONE_BYTES}) begin
              status <= ST_INVALID;
              state  <= S_DONE;
            end else begin
              status <= ST_OK;
              zn     <= zone;
              state  <= S_F_CHK;
            end
          end
        end
        S_A_CHK: begin
          if (si == cnt_z) begin
            if (zn_p1 == zones) begin
              status <= ST_NO_FIT;
              state  <= S_DONE;
            end else begin
              zn <= zn_p1[ZONE_W-1:0];
              si <= '0;
            end
          end else begin
            state <= S_A_CMP;
          end
        end
        S_A_CMP: begin
          if (ent.size >= len_r) begin
            out_zone   <= zn;
            out_offset <= ent.start;
            if (ent.size == len_r) begin
              if (si + CNT_W'(1) < cnt_z) begin
                si    <= si + CNT_W'(1);
                state <= S_SD_RD;
              end else begin
                cnt[zn] <= cnt_z - CNT_W'(1);
                state   <= S_DONE;
              end
            end else begin
              state <= S_DONE;
            end
          end else begin
            si    <= si + CNT_W'(1);
            state <= S_A_CHK;
          end
        end
        S_SD_RD: begin
          state <= S_SD_WR;
        end
        S_SD_WR: begin
          if (si + CNT_W'(1) == cnt_z) begin
            cnt[zn] <= cnt_z - CNT_W'(1);
            state   <= S_DONE;
          end else begin
            si    <= si + CNT_W'(1);
            state <= S_SD_RD;
          end
        end
        S_F_CHK: begin
          if (si == cnt_z) begin
            has_cur <= 1'b0;
            state   <= S_F_DEC;
          end else begin
            state <= S_F_CMP;
          end
        end
        S_F_CMP: begin
          if (ent.start < off_r) begin
            prev  <= ent;
            si    <= si + CNT_W'(1);
            state <= S_F_CHK;
          end else begin
            cur     <= ent;
            has_cur <= 1'b1;
            state   <= S_F_DEC;
          end
        end
        S_F_DEC: begin
          if (mp && ms) begin
            if (si + CNT_W'(1) < cnt_z) begin
              si    <= si + CNT_W'(1);
              state <= S_SD_RD;
            end else begin
              cnt[zn] <= cnt_z - CNT_W'(1);
              state   <= S_DONE;
            end
          end else if (mp || ms) begin
            state <= S_DONE;
          end else if (cnt_z >= EXTENTS_LIMIT) begin
            status <= ST_FULL;
            state  <= S_DONE;
          end else if (cnt_z == si) begin
            state <= S_F_INS;
          end else begin
            sj    <= cnt_z;
            state <= S_SU_RD;
          end
        end
        S_SU_RD: begin
          state <= S_SU_WR;
        end
        S_SU_WR: begin
          sj <= sj_m1;
          if (sj_m1 == si) begin
            state <= S_F_INS;
          end else begin
            state <= S_SU_RD;
          end
        end
        S_F_INS: begin
          cnt[zn] <= cnt_z + CNT_W'(1);
          state   <= S_DONE;
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");
  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (out_zone == '0 && out_offset == '0))
    else $error("location reported on a failed request");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_z <= EXTENTS_LIMIT) else $error("extent count above table size");
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    we |-> busy) else $error("table written while idle");
`endif

endmodule

[src/zffa_ram.sv]
// generic simple dual-port ram with registered read
// one write port, one read port; no dependencies
module zffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
